// ===== src/aar_pkg.sv =====
// shared types, constants and arithmetic helpers of the axis-angle rotation matrix block
package aar_pkg;

  // cordic datapath width, q.30 values with headroom
  localparam int CW = 34;
  // atan table depth
  localparam int TABLE_LEN = 24;
  // square root: radicand, root and remainder widths
  localparam int RAD_W = 48;
  localparam int ROOT_W = 24;
  localparam int REM_W = 26;
  // unit axis quotient bits, also the width of the radian angle magnitude
  localparam int UQ_W = 31;
  // axis length width and angle divisor width
  localparam int LEN_W = 24;
  localparam int ANG_DW = 29;

  localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
  localparam logic [ANG_DW-1:0] DEG_DEN = 29'd450000000;
  localparam logic [ANG_DW-1:0] DEG_HALF = 29'd225000000;
  // pi times 1e7, scaled by 2^22
  localparam longint unsigned RAD_NUM = 64'd31415926 << 22;
  localparam logic [14:0] FULL_TURN = 15'd23040;
  localparam logic [14:0] HALF_TURN = 15'd11520;
  localparam logic [14:0] QUARTER_TURN = 15'd5760;

  // one result item: nine q1.14 entries row-major and the zero axis flag
  typedef struct packed {
    logic [8:0][15:0] r;
    logic             zero_axis;
  } res_t;

  // atan(2^-i) in q.30, truncated
  function automatic logic [31:0] atan_q30(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // q.30 times q.30, rounded half up back to q.30
  function automatic logic signed [39:0] mul_q30(input logic signed [35:0] a,
                                                  input logic signed [35:0] b);
    logic signed [71:0] pr;
    pr = a * b;
    return 40'((pr + 72'sd536870912) >>> 30);
  endfunction

  // q.30 to q1.14 with rounding and saturation
  function automatic logic [15:0] to_q14(input logic signed [39:0] v);
    logic signed [39:0] t;
    logic [15:0] res;
    t = (v + 40'sd32768) >>> 16;
    if (t > 40'sd32767) res = 16'h7fff;
    else if (t < -40'sd32768) res = 16'h8000;
    else res = t[15:0];
    return res;
  endfunction

endpackage

// ===== src/aar_delay.sv =====
// enabled delay line for data that rides alongside the arithmetic cells
module aar_delay #(
  parameter int W = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  generate
    if (DEPTH == 0) begin : g_none
      assign dout = din;
    end else begin : g_taps
      logic [W-1:0] taps [DEPTH];
      // shift one tap per advancing cycle
      always_ff @(posedge clk) begin
        if (en) begin
          taps[0] <= din;
          for (int k = 1; k < DEPTH; k++) begin
            taps[k] <= taps[k-1];
          end
        end
      end
      assign dout = taps[DEPTH-1];
    end
  endgenerate

endmodule

// ===== src/aar_sqrt_cell.sv =====
// one digit of the restoring integer square root
module aar_sqrt_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [aar_pkg::REM_W-1:0]   prev_rem,
  input  logic [aar_pkg::ROOT_W-1:0]  prev_root,
  input  logic [aar_pkg::RAD_W-1:0]   prev_rad,
  output logic [aar_pkg::REM_W-1:0]   rem,
  output logic [aar_pkg::ROOT_W-1:0]  root,
  output logic [aar_pkg::RAD_W-1:0]   rad
);
  import aar_pkg::*;

  logic [REM_W+1:0] acc;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;

  // bring down two radicand bits and try 4*root+1
  always_comb begin
    acc   = {prev_rem, prev_rad[RAD_W-1 -: 2]};
    trial = {{(REM_W - ROOT_W){1'b0}}, prev_root, 2'b01};
    diff  = acc - trial;
    ge    = (acc >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= ge ? diff[REM_W-1:0] : acc[REM_W-1:0];
      root <= {prev_root[ROOT_W-2:0], ge};
      rad  <= {prev_rad[RAD_W-3:0], 2'b00};
    end
  end

endmodule

// ===== src/aar_div_cell.sv =====
// one quotient bit of a restoring long division
module aar_div_cell #(
  parameter int DW = 24,
  parameter int QW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] prev_rem,
  input  logic [QW-1:0] prev_lowq,
  input  logic [DW-1:0] prev_dvs,
  output logic [DW-1:0] rem,
  output logic [QW-1:0] lowq,
  output logic [DW-1:0] dvs
);

  logic [DW:0] acc;
  logic [DW:0] diff;
  logic        ge;

  // shift in the next dividend bit and compare against the divisor
  always_comb begin
    acc  = {prev_rem, prev_lowq[QW-1]};
    diff = acc - {1'b0, prev_dvs};
    ge   = (acc >= {1'b0, prev_dvs});
  end

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= ge ? diff[DW-1:0] : acc[DW-1:0];
      lowq <= {prev_lowq[QW-2:0], ge};
      dvs  <= prev_dvs;
    end
  end

endmodule

// ===== src/aar_cordic_cell.sv =====
// one micro-rotation of the cordic sine/cosine rotator
module aar_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [aar_pkg::CW-1:0] prev_x,
  input  logic signed [aar_pkg::CW-1:0] prev_y,
  input  logic signed [aar_pkg::CW-1:0] prev_z,
  output logic signed [aar_pkg::CW-1:0] x,
  output logic signed [aar_pkg::CW-1:0] y,
  output logic signed [aar_pkg::CW-1:0] z
);
  import aar_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] ang;

  // floor shifts and the angle step of this stage
  always_comb begin
    dx  = prev_y >>> STAGE;
    dy  = prev_x >>> STAGE;
    ang = $signed({{(CW-32){1'b0}}, atan_q30(STAGE)});
  end

  // rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (!prev_z[CW-1]) begin
        x <= prev_x - dx;
        y <= prev_y + dy;
        z <= prev_z - ang;
      end else begin
        x <= prev_x + dx;
        y <= prev_y - dy;
        z <= prev_z + ang;
      end
    end
  end

endmodule

// ===== src/axis_angle_rotation_matrix.sv =====
// top level: axis-angle to 3x3 rotation matrix pipeline
//
// Input channel: item_valid / item_stall with axis_x, axis_y, axis_z (signed
// Q2.13) and angle_deg (signed Q11.6 degrees, any value, wrapped mod 360).
// Output channel: result_valid / result_stall with r00..r22 (signed Q1.14,
// saturated) and zero_axis, set when the axis is all zero (matrix = cos*I).
// An item is taken at a clock edge where valid is high and stall is low.
//
// Throughput: one item per cycle while item_stall is low. The pipeline from
// the accepting edge to result_valid is set by the cell chain:
// 2 setup stages, 24 square root digit cells, 31 divider cells for the unit
// axis (the angle path runs a radian table lookup, one radian sum cell, a
// padding delay and CORDIC_STAGES cordic cells alongside, padded to match),
// 4 matrix stages, and the output register.
//
// Reset (rst, synchronous) empties the pipeline and the output; no clearing
// pass is needed. When the receiver stalls, one more item drains into a skid
// register; after that item_stall rises and the whole pipeline holds until
// the output moves again.
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [17:0] angle_deg,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [15:0] r00,
  output logic signed [15:0] r01,
  output logic signed [15:0] r02,
  output logic signed [15:0] r10,
  output logic signed [15:0] r11,
  output logic signed [15:0] r12,
  output logic signed [15:0] r20,
  output logic signed [15:0] r21,
  output logic signed [15:0] r22,
  output logic               zero_axis
);
  import aar_pkg::*;

  localparam int AXES = 3;
  localparam int PAD = ROOT_W + UQ_W - 1 - CORDIC_STAGES;
  localparam int NSTG = 2 + ROOT_W + UQ_W + 4;
  localparam int SIDE1_W = AXES * 16 + AXES + 1;
  localparam int PAD_W = UQ_W + 2;
  localparam int RS_W = ANG_DW + 2;

  // flow control
  logic            adv;
  logic            take;
  logic            sv;
  logic [NSTG-1:0] vld;
  logic            fin_v;
  res_t            fin;
  res_t            out_q;
  res_t            skid;

  assign adv        = !sv;
  assign item_stall = sv;
  assign take       = item_valid && !sv;
  assign fin_v      = vld[NSTG-1];

  // valid bit per pipeline stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], take};
    end
  end

  // ---------------- stage 1: squares, magnitudes, angle reduction
  logic signed [15:0]            ain [AXES];
  logic [AXES-1:0][30:0]         sq1;
  logic [AXES-1:0][15:0]         mag1;
  logic [AXES-1:0]               sgn1;
  logic signed [13:0]            ang_m1;
  logic                          neg1;
  logic [19:0]                   wrap;
  logic [14:0]                   mm;
  logic signed [15:0]            mfold;
  logic                          nfold;

  assign ain[0] = axis_x;
  assign ain[1] = axis_y;
  assign ain[2] = axis_z;

  // floor mod 360 degrees, then fold into +-90 degrees
  always_comb begin
    wrap = {{2{angle_deg[17]}}, angle_deg} + 20'd138240;
    for (int k = 3; k >= 0; k--) begin
      if (wrap >= (20'(FULL_TURN) << k)) wrap = wrap - (20'(FULL_TURN) << k);
    end
    mm = wrap[14:0];
    if (mm <= QUARTER_TURN) begin
      mfold = $signed({1'b0, mm});
      nfold = 1'b0;
    end else if (mm < (HALF_TURN + QUARTER_TURN)) begin
      mfold = $signed({1'b0, mm}) - $signed({1'b0, HALF_TURN});
      nfold = 1'b1;
    end else begin
      mfold = $signed({1'b0, mm}) - $signed({1'b0, FULL_TURN});
      nfold = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        sq1[i]  <= 31'(ain[i] * ain[i]);
        mag1[i] <= ain[i][15] ? 16'(-ain[i]) : 16'(ain[i]);
        sgn1[i] <= ain[i][15];
      end
      ang_m1 <= 14'(mfold);
      neg1   <= nfold;
    end
  end

  // ---------------- radian tables
  // 1/64 degree units times pi * 1e7 * 2^22 / 4.5e8, split by the high and low
  // magnitude bits; each part keeps its quotient and remainder by the divisor
  logic [31:0]       qh_tab [64];
  logic [ANG_DW-1:0] rh_tab [64];
  logic [31:0]       ql_tab [128];
  logic [ANG_DW-1:0] rl_tab [128];

  generate
    for (genvar g = 0; g < 64; g++) begin : g_hi_tab
      localparam longint unsigned NUM = 64'(g) * 64'd128 * RAD_NUM;
      assign qh_tab[g] = 32'(NUM / 64'(DEG_DEN));
      assign rh_tab[g] = ANG_DW'(NUM % 64'(DEG_DEN));
    end
    for (genvar g = 0; g < 128; g++) begin : g_lo_tab
      localparam longint unsigned NUM = 64'(g) * RAD_NUM;
      assign ql_tab[g] = 32'(NUM / 64'(DEG_DEN));
      assign rl_tab[g] = ANG_DW'(NUM % 64'(DEG_DEN));
    end
  endgenerate

  // ---------------- stage 2: sum of squares, radian table lookup
  logic [31:0]           ssum2;
  logic                  zero2;
  logic [AXES-1:0][15:0] mag2;
  logic [AXES-1:0]       sgn2;
  logic [31:0]           qh2;
  logic [ANG_DW-1:0]     rh2;
  logic [31:0]           ql2;
  logic [ANG_DW-1:0]     rl2;
  logic                  msgn2;
  logic                  neg2;
  logic [12:0]           mabs;

  assign mabs = ang_m1[13] ? 13'(-ang_m1) : 13'(ang_m1);

  always_ff @(posedge clk) begin
    if (adv) begin
      ssum2 <= 32'(sq1[0]) + 32'(sq1[1]) + 32'(sq1[2]);
      zero2 <= (sq1[0] == '0) && (sq1[1] == '0) && (sq1[2] == '0);
      mag2  <= mag1;
      sgn2  <= sgn1;
      qh2   <= qh_tab[mabs[12:7]];
      rh2   <= rh_tab[mabs[12:7]];
      ql2   <= ql_tab[mabs[6:0]];
      rl2   <= rl_tab[mabs[6:0]];
      msgn2 <= ang_m1[13];
      neg2  <= neg1;
    end
  end

  // ---------------- axis length: square root cells
  logic [REM_W-1:0]  sr_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] sr_root [ROOT_W+1];
  logic [RAD_W-1:0]  sr_rad  [ROOT_W+1];
  logic [SIDE1_W-1:0] side1;
  logic [AXES-1:0][15:0] mag3;
  logic [AXES-1:0]       sgn3;
  logic                  zero3a;

  assign sr_rem[0]  = '0;
  assign sr_root[0] = '0;
  assign sr_rad[0]  = {ssum2, 16'h0000};

  generate
    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      aar_sqrt_cell u_cell (
        .clk       (clk),
        .en        (adv),
        .prev_rem  (sr_rem[k]),
        .prev_root (sr_root[k]),
        .prev_rad  (sr_rad[k]),
        .rem       (sr_rem[k+1]),
        .root      (sr_root[k+1]),
        .rad       (sr_rad[k+1])
      );
    end
  endgenerate

  aar_delay #(.W(SIDE1_W), .DEPTH(ROOT_W)) u_side_sqrt (
    .clk  (clk),
    .en   (adv),
    .din  ({mag2, sgn2, zero2}),
    .dout (side1)
  );

  assign {mag3, sgn3, zero3a} = side1;

  // ---------------- unit axis: divider cells, one chain per component
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] dv_rem  [AXES][UQ_W+1];
  logic [UQ_W-1:0]  dv_lowq [AXES][UQ_W+1];
  logic [LEN_W-1:0] dv_dvs  [AXES][UQ_W+1];
  logic [AXES:0]    side2;

  // a zero axis divides by one and stays zero
  assign len = zero3a ? LEN_W'(1) : sr_root[ROOT_W];

  generate
    for (genvar i = 0; i < AXES; i++) begin : g_lane
      logic [54:0] num;
      // rounded dividend: |a| * 2^38 + len / 2
      assign num = {1'b0, mag3[i], 38'h0} + 55'(len[LEN_W-1:1]);
      assign dv_rem[i][0]  = num[54:31];
      assign dv_lowq[i][0] = num[30:0];
      assign dv_dvs[i][0]  = len;
      for (genvar k = 0; k < UQ_W; k++) begin : g_div
        aar_div_cell #(.DW(LEN_W), .QW(UQ_W)) u_cell (
          .clk       (clk),
          .en        (adv),
          .prev_rem  (dv_rem[i][k]),
          .prev_lowq (dv_lowq[i][k]),
          .prev_dvs  (dv_dvs[i][k]),
          .rem       (dv_rem[i][k+1]),
          .lowq      (dv_lowq[i][k+1]),
          .dvs       (dv_dvs[i][k+1])
        );
      end
    end
  endgenerate

  aar_delay #(.W(AXES + 1), .DEPTH(UQ_W)) u_side_div (
    .clk  (clk),
    .en   (adv),
    .din  ({sgn3, zero3a}),
    .dout (side2)
  );

  // ---------------- angle: radian sum cell, pad, cordic cells
  logic [RS_W-1:0]    rsum;
  logic [1:0]         corr;
  logic [UQ_W-1:0]    theta3;
  logic               msgn3;
  logic               neg3;
  logic [PAD_W-1:0]   padded;
  logic [UQ_W-1:0]    theta_p;
  logic               msgn_p;
  logic               neg_p;
  logic signed [CW-1:0] co_x [CORDIC_STAGES+1];
  logic signed [CW-1:0] co_y [CORDIC_STAGES+1];
  logic signed [CW-1:0] co_z [CORDIC_STAGES+1];
  logic               neg_c;

  // both remainders plus the rounding half add zero, one or two units
  always_comb begin
    rsum = RS_W'(rh2) + RS_W'(rl2) + RS_W'(DEG_HALF);
    if (rsum >= (RS_W'(DEG_DEN) << 1)) corr = 2'd2;
    else if (rsum >= RS_W'(DEG_DEN)) corr = 2'd1;
    else corr = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      theta3 <= UQ_W'(qh2 + ql2 + 32'(corr));
      msgn3  <= msgn2;
      neg3   <= neg2;
    end
  end

  aar_delay #(.W(PAD_W), .DEPTH(PAD)) u_pad (
    .clk  (clk),
    .en   (adv),
    .din  ({theta3, msgn3, neg3}),
    .dout (padded)
  );

  assign {theta_p, msgn_p, neg_p} = padded;

  // signed theta in q.30 radians enters the rotator
  assign co_x[0] = CW'(CORDIC_GAIN);
  assign co_y[0] = '0;
  assign co_z[0] = msgn_p ? -$signed({3'b000, theta_p})
                          :  $signed({3'b000, theta_p});

  generate
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      aar_cordic_cell #(.STAGE(k)) u_cell (
        .clk    (clk),
        .en     (adv),
        .prev_x (co_x[k]),
        .prev_y (co_y[k]),
        .prev_z (co_z[k]),
        .x      (co_x[k+1]),
        .y      (co_y[k+1]),
        .z      (co_z[k+1])
      );
    end
  endgenerate

  aar_delay #(.W(1), .DEPTH(CORDIC_STAGES)) u_side_cordic (
    .clk  (clk),
    .en   (adv),
    .din  (neg_p),
    .dout (neg_c)
  );

  // ---------------- matrix stage 1: signed unit axis, sine and cosine
  logic signed [31:0]   u1 [AXES];
  logic signed [CW-1:0] c1;
  logic signed [CW-1:0] s1;
  logic                 zero_m1;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        u1[i] <= side2[i+1] ? -$signed({1'b0, dv_lowq[i][UQ_W]})
                            :  $signed({1'b0, dv_lowq[i][UQ_W]});
      end
      c1      <= neg_c ? -co_x[CORDIC_STAGES] : co_x[CORDIC_STAGES];
      s1      <= neg_c ? -co_y[CORDIC_STAGES] : co_y[CORDIC_STAGES];
      zero_m1 <= side2[0];
    end
  end

  // ---------------- matrix stage 2: outer product, sine terms, 1 - cos
  // outer product order: 00, 11, 22, 01, 02, 12
  logic signed [31:0]   p2 [6];
  logic signed [CW-1:0] su2 [AXES];
  logic signed [34:0]   omc2;
  logic signed [CW-1:0] c2;
  logic                 zero_m2;

  always_ff @(posedge clk) begin
    if (adv) begin
      p2[0] <= 32'(mul_q30(36'(u1[0]), 36'(u1[0])));
      p2[1] <= 32'(mul_q30(36'(u1[1]), 36'(u1[1])));
      p2[2] <= 32'(mul_q30(36'(u1[2]), 36'(u1[2])));
      p2[3] <= 32'(mul_q30(36'(u1[0]), 36'(u1[1])));
      p2[4] <= 32'(mul_q30(36'(u1[0]), 36'(u1[2])));
      p2[5] <= 32'(mul_q30(36'(u1[1]), 36'(u1[2])));
      for (int i = 0; i < AXES; i++) begin
        su2[i] <= CW'(mul_q30(36'(s1), 36'(u1[i])));
      end
      omc2    <= 35'sd1073741824 - 35'(c1);
      c2      <= c1;
      zero_m2 <= zero_m1;
    end
  end

  // ---------------- matrix stage 3: scale outer product by 1 - cos
  logic signed [35:0]   t3 [6];
  logic signed [CW-1:0] su3 [AXES];
  logic signed [CW-1:0] c3;
  logic                 zero_m3;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        t3[k] <= 36'(mul_q30(36'(omc2), 36'(p2[k])));
      end
      su3     <= su2;
      c3      <= c2;
      zero_m3 <= zero_m2;
    end
  end

  // ---------------- matrix stage 4: add diagonal and cross terms, saturate
  logic signed [39:0] cx;
  logic signed [39:0] sx [AXES];
  logic signed [39:0] tx [6];

  always_comb begin
    cx = 40'(c3);
    for (int i = 0; i < AXES; i++) sx[i] = 40'(su3[i]);
    for (int k = 0; k < 6; k++) tx[k] = 40'(t3[k]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin.r[0]      <= to_q14(tx[0] + cx);
      fin.r[1]      <= to_q14(tx[3] - sx[2]);
      fin.r[2]      <= to_q14(tx[4] + sx[1]);
      fin.r[3]      <= to_q14(tx[3] + sx[2]);
      fin.r[4]      <= to_q14(tx[1] + cx);
      fin.r[5]      <= to_q14(tx[5] - sx[0]);
      fin.r[6]      <= to_q14(tx[4] - sx[1]);
      fin.r[7]      <= to_q14(tx[5] + sx[0]);
      fin.r[8]      <= to_q14(tx[2] + cx);
      fin.zero_axis <= zero_m3;
    end
  end

  // ---------------- output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sv           <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (sv) begin
        result_valid <= 1'b1;
        sv           <= 1'b0;
      end else begin
        result_valid <= fin_v;
      end
    end else if (fin_v && adv) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      out_q <= sv ? skid : fin;
    end else if (fin_v && adv) begin
      skid <= fin;
    end
  end

  assign r00       = $signed(out_q.r[0]);
  assign r01       = $signed(out_q.r[1]);
  assign r02       = $signed(out_q.r[2]);
  assign r10       = $signed(out_q.r[3]);
  assign r11       = $signed(out_q.r[4]);
  assign r12       = $signed(out_q.r[5]);
  assign r20       = $signed(out_q.r[6]);
  assign r21       = $signed(out_q.r[7]);
  assign r22       = $signed(out_q.r[8]);
  assign zero_axis = out_q.zero_axis;

  // ---------------- assertions
  // the skid only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sv |-> result_valid)
    else $error("skid holds an item while the output register is empty");

  // a finished item leaving into a stalled output lands in the skid
  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    (fin_v && !sv && result_valid && result_stall) |=> sv)
    else $error("finished item dropped while the output was stalled");

  // a zero axis gives cos times identity
  a_zero_axis_diag: assert property (@(posedge clk) disable iff (rst)
    (result_valid && zero_axis) |->
      (r01 == 16'sd0 && r02 == 16'sd0 && r10 == 16'sd0 && r12 == 16'sd0 &&
       r20 == 16'sd0 && r21 == 16'sd0 && r00 == r11 && r11 == r22))
    else $error("zero axis item is not a scaled identity");

endmodule
